// ===== src/fpa_pkg.sv =====
// ============================================================================
// Fixed-point ALU package
// Operation codes and the opcode width used by the ALU core and its testbench.
// ============================================================================
package fpa_pkg;

    typedef enum logic [3:0] {
        OP_ADD = 4'd0,
        OP_SUB = 4'd1,
        OP_MUL = 4'd2,
        OP_DIV = 4'd3,
        OP_LT  = 4'd4,
        OP_GT  = 4'd5,
        OP_LE  = 4'd6,
        OP_GE  = 4'd7,
        OP_EQ  = 4'd8,
        OP_NE  = 4'd9,
        OP_MIN = 4'd10,
        OP_MAX = 4'd11,
        OP_INC = 4'd12,
        OP_DEC = 4'd13
    } t_op;

    localparam int unsigned OP_BITS = 4;

endpackage

// ===== src/fpa_mul.sv =====
// ============================================================================
// Fixed-point multiplier
// Three-stage magnitude multiply with rounding and saturation.
// ============================================================================
module fpa_mul #(
    parameter int unsigned WORD_BITS     = 32,
    parameter int unsigned FRACTION_BITS = 8
) (
    input  logic                        i_clk,
    input  logic [2:0]                  i_adv,
    input  logic signed [WORD_BITS-1:0] i_a,
    input  logic signed [WORD_BITS-1:0] i_b,
    output logic signed [WORD_BITS-1:0] o_value,
    output logic                        o_overflow
);
    localparam int unsigned HB = WORD_BITS / 2;
    localparam int unsigned LB = WORD_BITS - HB;
    localparam int unsigned PB = 2 * WORD_BITS;

    logic [WORD_BITS-1:0] ma, mb;
    logic [PB-1:0]        r_p0, r_p1, r_p2, r_p3;
    logic                 r_neg1, r_neg2;
    logic [PB:0]          n_sum;
    logic [PB:0]          r_sum;
    logic [PB:0]          shifted;
    logic [PB:0]          limit;
    logic [WORD_BITS-1:0] n_val;
    logic                 n_ovf;
    logic [WORD_BITS-1:0] r_val;
    logic                 r_ovf;

    assign ma = i_a[WORD_BITS-1] ? WORD_BITS'(-i_a) : WORD_BITS'(i_a);
    assign mb = i_b[WORD_BITS-1] ? WORD_BITS'(-i_b) : WORD_BITS'(i_b);

    // Stage 1: four half-width partial products.
    always_ff @(posedge i_clk) begin
        if (i_adv[0]) begin
            r_p0   <= PB'(ma[LB-1:0]) * PB'(mb[LB-1:0]);
            r_p1   <= PB'(ma[LB-1:0]) * PB'(mb[WORD_BITS-1:LB]);
            r_p2   <= PB'(ma[WORD_BITS-1:LB]) * PB'(mb[LB-1:0]);
            r_p3   <= PB'(ma[WORD_BITS-1:LB]) * PB'(mb[WORD_BITS-1:LB]);
            r_neg1 <= i_a[WORD_BITS-1] ^ i_b[WORD_BITS-1];
        end
    end

    // Stage 2: sum with the rounding half.
    always_comb begin
        n_sum = (PB+1)'(r_p0) + ((PB+1)'(r_p1) << LB) + ((PB+1)'(r_p2) << LB)
              + ((PB+1)'(r_p3) << (2 * LB));
        if (FRACTION_BITS > 0) begin
            n_sum = n_sum + ((PB+1)'(1) << (FRACTION_BITS - 1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv[1]) begin
            r_sum  <= n_sum;
            r_neg2 <= r_neg1;
        end
    end

    // Stage 3: scale, saturate and restore the sign.
    always_comb begin
        shifted = r_sum >> FRACTION_BITS;
        limit   = (PB+1)'(1) << (WORD_BITS - 1);
        if (!r_neg2) begin
            limit = limit - (PB+1)'(1);
        end
        n_ovf = shifted > limit;
        n_val = n_ovf ? limit[WORD_BITS-1:0] : shifted[WORD_BITS-1:0];
        if (r_neg2) begin
            n_val = -n_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv[2]) begin
            r_val <= n_val;
            r_ovf <= n_ovf;
        end
    end

    assign o_value    = $signed(r_val);
    assign o_overflow = r_ovf;
endmodule

// ===== src/fpa_div.sv =====
// ============================================================================
// Fixed-point divider
// Pipelined restoring divider, BPS quotient bits per stage, with rounding.
// ============================================================================
module fpa_div #(
    parameter int unsigned WORD_BITS     = 32,
    parameter int unsigned FRACTION_BITS = 8,
    parameter int unsigned STAGES        = 5
) (
    input  logic                        i_clk,
    input  logic [STAGES+1:0]           i_adv,
    input  logic signed [WORD_BITS-1:0] i_a,
    input  logic signed [WORD_BITS-1:0] i_b,
    output logic signed [WORD_BITS-1:0] o_value,
    output logic                        o_overflow
);
    localparam int unsigned NB  = WORD_BITS + FRACTION_BITS;
    localparam int unsigned BPS = (NB + STAGES - 1) / STAGES;
    localparam int unsigned TB  = BPS * STAGES;
    localparam int unsigned RB  = WORD_BITS + 1;

    // Per-stage pipeline of numerator/quotient shift word, remainder, divisor.
    logic [TB-1:0]        r_nq  [STAGES+1];
    logic [RB-1:0]        r_rem [STAGES+1];
    logic [WORD_BITS-1:0] r_d   [STAGES+1];
    logic                 r_neg [STAGES+1];
    logic [WORD_BITS-1:0] ma, mb;
    logic [WORD_BITS-1:0] r_val;
    logic                 r_ovf;

    assign ma = i_a[WORD_BITS-1] ? WORD_BITS'(-i_a) : WORD_BITS'(i_a);
    assign mb = i_b[WORD_BITS-1] ? WORD_BITS'(-i_b) : WORD_BITS'(i_b);

    always_ff @(posedge i_clk) begin
        if (i_adv[0]) begin
            r_nq[0]  <= TB'(ma) << FRACTION_BITS;
            r_rem[0] <= '0;
            r_d[0]   <= mb;
            r_neg[0] <= i_a[WORD_BITS-1] ^ i_b[WORD_BITS-1];
        end
    end

    for (genvar s = 0; s < STAGES; s++) begin : g_stage
        logic [TB-1:0] nq;
        logic [RB-1:0] rem;
        always_comb begin
            nq  = r_nq[s];
            rem = r_rem[s];
            for (int k = 0; k < BPS; k++) begin
                rem = {rem[RB-2:0], nq[TB-1]};
                nq  = {nq[TB-2:0], 1'b0};
                if (rem >= RB'(r_d[s])) begin
                    rem   = rem - RB'(r_d[s]);
                    nq[0] = 1'b1;
                end
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_adv[s+1]) begin
                r_nq[s+1]  <= nq;
                r_rem[s+1] <= rem;
                r_d[s+1]   <= r_d[s];
                r_neg[s+1] <= r_neg[s];
            end
        end
    end

    // Final stage: round half up on the remainder, saturate and sign.
    logic [TB:0]          q;
    logic [TB:0]          limit;
    logic [WORD_BITS-1:0] n_val;
    logic                 n_ovf;

    always_comb begin
        q = (TB+1)'(r_nq[STAGES]);
        if ({r_rem[STAGES], 1'b0} >= (RB+1)'(r_d[STAGES])) begin
            q = q + (TB+1)'(1);
        end
        limit = (TB+1)'(1) << (WORD_BITS - 1);
        if (!r_neg[STAGES]) begin
            limit = limit - (TB+1)'(1);
        end
        n_ovf = q > limit;
        n_val = n_ovf ? limit[WORD_BITS-1:0] : q[WORD_BITS-1:0];
        if (r_neg[STAGES]) begin
            n_val = -n_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv[STAGES+1]) begin
            r_val <= n_val;
            r_ovf <= n_ovf;
        end
    end

    assign o_value    = $signed(r_val);
    assign o_overflow = r_ovf;
endmodule

// ===== src/fixed_point_alu_core.sv =====
// ============================================================================
// Fixed-point ALU core
// Pipelined signed fixed-point ALU with rounding, saturation and flags.
// ============================================================================
// Usage: drive i_operation, i_operand_a and i_operand_b and raise start.
// A transaction is accepted at each rising edge where start is high and busy
// is low. busy is held low: the pipeline never stalls, so one transaction may
// enter in every cycle, back to back.
// Every transaction produces exactly one result, in order. The result sits
// on o_result_value and the flag outputs for one cycle, marked by o_done.
// The receiver cannot stall, so no result is ever held back.
// All operations run through the same pipe depth: the divider sets the depth
// with its input register, its restoring stages retiring ceil((WORD_BITS +
// FRACTION_BITS) / DIV_STAGES) quotient bits each, and its rounding stage;
// the multiplier and the simple operations are padded to match.
// A synchronous active-low reset clears the valid bits; payload registers
// are not reset. Opcodes 14 and 15 return all-zero results.
// ============================================================================
module fixed_point_alu_core #(
    parameter int unsigned WORD_BITS     = 32,
    parameter int unsigned FRACTION_BITS = 8,
    parameter int unsigned DIV_STAGES    = 5
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [fpa_pkg::OP_BITS-1:0]      i_operation,
    input  logic signed [WORD_BITS-1:0]      i_operand_a,
    input  logic signed [WORD_BITS-1:0]      i_operand_b,
    output logic                             o_done,
    output logic signed [WORD_BITS-1:0]      o_result_value,
    output logic                             o_compare_true,
    output logic                             o_overflow,
    output logic                             o_divide_by_zero
);
    localparam int unsigned LAT = DIV_STAGES + 2;

    // Valid bits; stage LAT-1 drives o_done and the result outputs.
    logic [LAT-1:0] r_vld;
    logic           accept;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[LAT-2:0], accept};
        end
    end

    // Simple operations are resolved in stage one and delayed alongside.
    logic [WORD_BITS-1:0] smp_val;
    logic                 smp_cmp, smp_ovf, smp_dz;
    logic [WORD_BITS-1:0] sum, dif;
    logic                 lt, sa, sb;
    logic [WORD_BITS-1:0] maxp, maxn;

    always_comb begin
        sa      = i_operand_a[WORD_BITS-1];
        sb      = i_operand_b[WORD_BITS-1];
        maxp    = {1'b0, {(WORD_BITS-1){1'b1}}};
        maxn    = {1'b1, {(WORD_BITS-1){1'b0}}};
        lt      = i_operand_a < i_operand_b;
        smp_val = '0;
        smp_cmp = 1'b0;
        smp_ovf = 1'b0;
        smp_dz  = 1'b0;
        sum     = i_operand_a + i_operand_b;
        dif     = i_operand_a - i_operand_b;
        unique case (fpa_pkg::t_op'(i_operation))
            fpa_pkg::OP_ADD: begin
                smp_val = sum;
                if (sa == sb && sum[WORD_BITS-1] != sa) begin
                    smp_ovf = 1'b1;
                    smp_val = sa ? maxn : maxp;
                end
            end
            fpa_pkg::OP_SUB: begin
                smp_val = dif;
                if (sa != sb && dif[WORD_BITS-1] != sa) begin
                    smp_ovf = 1'b1;
                    smp_val = sa ? maxn : maxp;
                end
            end
            fpa_pkg::OP_DIV: begin
                if (i_operand_b == '0) begin
                    smp_dz  = 1'b1;
                    smp_val = sa ? maxn : maxp;
                end
            end
            fpa_pkg::OP_LT: smp_cmp = lt;
            fpa_pkg::OP_GT: smp_cmp = i_operand_b < i_operand_a;
            fpa_pkg::OP_LE: smp_cmp = !(i_operand_b < i_operand_a);
            fpa_pkg::OP_GE: smp_cmp = !lt;
            fpa_pkg::OP_EQ: smp_cmp = i_operand_a == i_operand_b;
            fpa_pkg::OP_NE: smp_cmp = i_operand_a != i_operand_b;
            fpa_pkg::OP_MIN: smp_val = lt ? i_operand_a : i_operand_b;
            fpa_pkg::OP_MAX: smp_val = lt ? i_operand_b : i_operand_a;
            fpa_pkg::OP_INC: begin
                if (i_operand_a == maxp) begin
                    smp_ovf = 1'b1;
                    smp_val = maxp;
                end else begin
                    smp_val = i_operand_a + WORD_BITS'(1);
                end
            end
            fpa_pkg::OP_DEC: begin
                if (i_operand_a == maxn) begin
                    smp_ovf = 1'b1;
                    smp_val = maxn;
                end else begin
                    smp_val = i_operand_a - WORD_BITS'(1);
                end
            end
            default: ;
        endcase
    end

    // Side-band pipe: simple result and which unit supplies the final word.
    typedef struct packed {
        logic [WORD_BITS-1:0] val;
        logic                 cmp;
        logic                 ovf;
        logic                 dz;
        logic                 use_mul;
        logic                 use_div;
    } t_side;

    t_side r_side [LAT];

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_side[0].val     <= smp_val;
            r_side[0].cmp     <= smp_cmp;
            r_side[0].ovf     <= smp_ovf;
            r_side[0].dz      <= smp_dz;
            r_side[0].use_mul <= i_operation == fpa_pkg::OP_MUL;
            r_side[0].use_div <= i_operation == fpa_pkg::OP_DIV && i_operand_b != '0;
        end
        for (int s = 1; s < LAT; s++) begin
            if (r_vld[s-1]) begin
                r_side[s] <= r_side[s-1];
            end
        end
    end

    // Multiplier finishes at stage 3; delay its output to the common depth.
    logic [WORD_BITS-1:0] mul_val, div_val;
    logic                 mul_ovf, div_ovf;
    logic [WORD_BITS-1:0] r_mdl_val [LAT-3];
    logic                 r_mdl_ovf [LAT-3];

    fpa_mul #(
        .WORD_BITS    (WORD_BITS),
        .FRACTION_BITS(FRACTION_BITS)
    ) u_mul (
        .i_clk     (i_clk),
        .i_adv     ({r_vld[1:0], accept}),
        .i_a       (i_operand_a),
        .i_b       (i_operand_b),
        .o_value   (mul_val),
        .o_overflow(mul_ovf)
    );

    always_ff @(posedge i_clk) begin
        for (int s = 0; s < LAT - 3; s++) begin
            if (r_vld[s+2]) begin
                r_mdl_val[s] <= (s == 0) ? mul_val : r_mdl_val[(s == 0) ? 0 : s-1];
                r_mdl_ovf[s] <= (s == 0) ? mul_ovf : r_mdl_ovf[(s == 0) ? 0 : s-1];
            end
        end
    end

    fpa_div #(
        .WORD_BITS    (WORD_BITS),
        .FRACTION_BITS(FRACTION_BITS),
        .STAGES       (DIV_STAGES)
    ) u_div (
        .i_clk     (i_clk),
        .i_adv     ({r_vld[LAT-2:0], accept}),
        .i_a       (i_operand_a),
        .i_b       (i_operand_b),
        .o_value   (div_val),
        .o_overflow(div_ovf)
    );

    // Output selection at the last stage.
    always_comb begin
        o_result_value   = $signed(r_side[LAT-1].val);
        o_overflow       = r_side[LAT-1].ovf;
        if (r_side[LAT-1].use_mul) begin
            o_result_value = $signed(r_mdl_val[LAT-4]);
            o_overflow     = r_mdl_ovf[LAT-4];
        end else if (r_side[LAT-1].use_div) begin
            o_result_value = div_val;
            o_overflow     = div_ovf;
        end
        o_compare_true   = r_side[LAT-1].cmp;
        o_divide_by_zero = r_side[LAT-1].dz;
    end

    assign o_done = r_vld[LAT-1];

`ifndef SYNTHESIS
    // An accepted transaction shows up as o_done once it has passed the valid pipe.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##LAT o_done)
        else $error("result did not appear at the fixed latency");

    // Divide-by-zero never reports overflow at the same time.
    a_dz_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_divide_by_zero |-> !o_overflow)
        else $error("divide by zero flagged together with overflow");

    // A compare result always carries a zero raw value.
    a_cmp_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_compare_true |-> o_result_value == '0 && !o_overflow)
        else $error("compare result carries a value");
`endif
endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Fixed-point ALU core testbench
// Drives directed corner cases and random operations through the Q24.8 ALU,
// predicts every result with exact wide integer arithmetic, and compares each
// result strobe field by field against the oldest pending expectation.
// ----------------------------------------------------------------------------

class alu_scoreboard;
    typedef struct packed {
        logic signed [31:0] value;
        logic               cmp;
        logic               ovf;
        logic               dz;
    } t_alu_result;

    t_alu_result pending[$];
    int          errors;

    function new();
        errors = 0;
    endfunction

    // Saturate an already rounded magnitude by sign, then apply the sign.
    static function t_alu_result pack_magnitude(bit neg, logic [127:0] mag);
        t_alu_result r;
        r = '0;
        if (!neg && mag > 128'h7FFF_FFFF) begin
            r.value = 32'sh7FFF_FFFF;
            r.ovf   = 1'b1;
        end else if (neg && mag > 128'h8000_0000) begin
            r.value = 32'sh8000_0000;
            r.ovf   = 1'b1;
        end else begin
            r.value = neg ? -mag[31:0] : mag[31:0];
        end
        return r;
    endfunction

    static function t_alu_result alu_predict(logic [3:0] op, logic signed [31:0] a,
                                             logic signed [31:0] b);
        t_alu_result        r;
        logic signed [32:0] wide_sum;
        logic [127:0]       mag_a;
        logic [127:0]       mag_b;
        logic [127:0]       prod;
        logic [127:0]       quot;
        logic [127:0]       remd;
        bit                 neg;
        r     = '0;
        mag_a = a[31] ? 128'(-64'(a)) : 128'(a);
        mag_b = b[31] ? 128'(-64'(b)) : 128'(b);
        neg   = a[31] ^ b[31];
        case (op)
            fpa_pkg::OP_ADD, fpa_pkg::OP_SUB, fpa_pkg::OP_INC, fpa_pkg::OP_DEC: begin
                case (op)
                    fpa_pkg::OP_ADD: wide_sum = 33'(a) + 33'(b);
                    fpa_pkg::OP_SUB: wide_sum = 33'(a) - 33'(b);
                    fpa_pkg::OP_INC: wide_sum = 33'(a) + 33'sd1;
                    default:         wide_sum = 33'(a) - 33'sd1;
                endcase
                if (wide_sum > 33'sh0_7FFF_FFFF) begin
                    r.value = 32'sh7FFF_FFFF;
                    r.ovf   = 1'b1;
                end else if (wide_sum < -33'sh0_8000_0000) begin
                    r.value = 32'sh8000_0000;
                    r.ovf   = 1'b1;
                end else begin
                    r.value = wide_sum[31:0];
                end
            end
            fpa_pkg::OP_MUL: begin
                prod = mag_a * mag_b + 128'd128;
                r    = pack_magnitude(neg, prod >> 8);
            end
            fpa_pkg::OP_DIV: begin
                if (b == 0) begin
                    r.dz    = 1'b1;
                    r.value = a[31] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
                end else begin
                    quot = (mag_a << 8) / mag_b;
                    remd = (mag_a << 8) % mag_b;
                    if ((remd << 1) >= mag_b)
                        quot = quot + 1;
                    r = pack_magnitude(neg, quot);
                end
            end
            fpa_pkg::OP_LT:  r.cmp = a <  b;
            fpa_pkg::OP_GT:  r.cmp = a >  b;
            fpa_pkg::OP_LE:  r.cmp = a <= b;
            fpa_pkg::OP_GE:  r.cmp = a >= b;
            fpa_pkg::OP_EQ:  r.cmp = a == b;
            fpa_pkg::OP_NE:  r.cmp = a != b;
            fpa_pkg::OP_MIN: r.value = (a < b) ? a : b;
            fpa_pkg::OP_MAX: r.value = (a < b) ? b : a;
            default: ;
        endcase
        return r;
    endfunction

    function void note_operation(logic [3:0] op, logic signed [31:0] a,
                                 logic signed [31:0] b);
        pending.push_back(alu_predict(op, a, b));
    endfunction

    function void check_result(t_alu_result got);
        t_alu_result exp_r;
        if (pending.size() == 0) begin
            $display("%0t: unexpected result value=%h cmp=%b ovf=%b dz=%b", $realtime,
                     got.value, got.cmp, got.ovf, got.dz);
            errors++;
            return;
        end
        exp_r = pending.pop_front();
        if (got.value !== exp_r.value) begin
            $display("%0t: result_value expected %h actual %h", $realtime,
                     exp_r.value, got.value);
            errors++;
        end
        if (got.cmp !== exp_r.cmp) begin
            $display("%0t: compare_true expected %b actual %b", $realtime,
                     exp_r.cmp, got.cmp);
            errors++;
        end
        if (got.ovf !== exp_r.ovf) begin
            $display("%0t: overflow expected %b actual %b", $realtime,
                     exp_r.ovf, got.ovf);
            errors++;
        end
        if (got.dz !== exp_r.dz) begin
            $display("%0t: divide_by_zero expected %b actual %b", $realtime,
                     exp_r.dz, got.dz);
            errors++;
        end
    endfunction
endclass

// ===== tb/testbench_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Fixed-point ALU core testbench top
// Clock, reset, command driver and result monitor around the ALU core. Every
// accepted transaction is noted with the scoreboard; every o_done strobe is
// checked against the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;

    // Pipeline depth of the core with its default parameters.
    localparam int PIPE_LATENCY   = 7;
    localparam int RANDOM_ITEMS   = 1350;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic [3:0]         i_operation;
    logic signed [31:0] i_operand_a;
    logic signed [31:0] i_operand_b;
    logic               o_done;
    logic signed [31:0] o_result_value;
    logic               o_compare_true;
    logic               o_overflow;
    logic               o_divide_by_zero;

    alu_scoreboard alu_sb;
    logic signed [31:0] corner_values [8];

    fixed_point_alu_core u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_operation     (i_operation),
        .i_operand_a     (i_operand_a),
        .i_operand_b     (i_operand_b),
        .o_done          (o_done),
        .o_result_value  (o_result_value),
        .o_compare_true  (o_compare_true),
        .o_overflow      (o_overflow),
        .o_divide_by_zero(o_divide_by_zero)
    );

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    // Monitor: results cannot be stalled, so each o_done cycle is one result.
    always @(posedge i_clk) begin
        if (i_rst_n && o_done === 1'b1) begin
            alu_sb.check_result({o_result_value, o_compare_true, o_overflow,
                                 o_divide_by_zero});
        end
    end

    // Drives one command transaction. The start line stays high across
    // back-to-back transactions, so it is only lowered when a gap follows.
    task automatic send_operation(logic [3:0] op, logic signed [31:0] a,
                                  logic signed [31:0] b, int gap);
        start       <= 1'b1;
        i_operation <= op;
        i_operand_a <= a;
        i_operand_b <= b;
        @(posedge i_clk);
        while (busy !== 1'b0)
            @(posedge i_clk);
        alu_sb.note_operation(op, a, b);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Random gap, with long runs of back-to-back traffic mixed in.
    function automatic int draw_gap(bit burst);
        return burst ? 0 : $urandom_range(0, 14);
    endfunction

    // Operands biased toward boundaries, small values and exact multiples so
    // that rounding ties, saturation and equality all get exercised.
    function automatic logic signed [31:0] draw_operand();
        case ($urandom_range(0, 5))
            0:       return corner_values[$urandom_range(0, 7)];
            1:       return $signed(32'($urandom_range(0, 4096))) - 32'sd2048;
            2:       return $signed($urandom()) >>> $urandom_range(0, 31);
            3:       return $signed(32'($urandom_range(0, 64)) << 7)
                            * ($urandom_range(0, 1) ? 1 : -1);
            default: return $signed($urandom());
        endcase
    endfunction

    initial begin
        bit burst;
        logic [3:0] op;
        logic signed [31:0] a;
        logic signed [31:0] b;
        alu_sb = new();
        corner_values = '{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sd0, 32'sd1, -32'sd1,
                          32'sd256, -32'sd256, 32'sh8000_0001};
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_operation = '0;
        i_operand_a = '0;
        i_operand_b = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: every operation once, the two unused codes, and the
        // saturation, rounding-tie and divide-by-zero corners.
        for (int k = 0; k < 16; k++)
            send_operation(4'(k), 32'sd1000, -32'sd384, k % 3);
        send_operation(fpa_pkg::OP_ADD, 32'sh7FFF_FFFF, 32'sd1, 0);
        send_operation(fpa_pkg::OP_SUB, 32'sh8000_0000, 32'sd1, 1);
        send_operation(fpa_pkg::OP_MUL, 32'sh8000_0000, 32'sh8000_0000, 0);
        send_operation(fpa_pkg::OP_MUL, 32'sd1, 32'sd128, 0);
        send_operation(fpa_pkg::OP_MUL, -32'sd1, 32'sd128, 2);
        send_operation(fpa_pkg::OP_DIV, 32'sd5, 32'sd0, 0);
        send_operation(fpa_pkg::OP_DIV, 32'sh8000_0000, 32'sd0, 0);
        send_operation(fpa_pkg::OP_DIV, 32'sh8000_0000, -32'sd1, 3);
        send_operation(fpa_pkg::OP_INC, 32'sh7FFF_FFFF, 32'shFFFF_FFFF, 0);
        send_operation(fpa_pkg::OP_DEC, 32'sh8000_0000, 32'sd0, 0);

        burst = 1'b0;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if ($urandom_range(0, 39) == 0)
                burst = ~burst;
            op = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(14, 15))
                                              : 4'($urandom_range(0, 13));
            a = draw_operand();
            b = ($urandom_range(0, 9) == 0) ? a : draw_operand();
            send_operation(op, a, b, draw_gap(burst));
        end
        start <= 1'b0;

        while (alu_sb.pending.size() != 0)
            @(posedge i_clk);
        repeat (PIPE_LATENCY + 4) @(posedge i_clk);
        if (alu_sb.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end
endmodule
